>>> rtl/core/brje_pkg.sv
package brje_pkg;

  // Width of the reported fill count; wider counts are truncated.
  localparam int unsigned COUNT_W = 11;

  // Action codes of an input transfer.
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Characters used by the escape sequences.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_char;
    logic               last_of_run;
    logic               was_empty;
    logic               dropped_oldest;
    logic [COUNT_W-1:0] stored_count;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_e;

  // Number of characters in the escape of byte c.
  function automatic logic [2:0] esc_len(input logic [7:0] c);
    logic [2:0] n;
    if (c == CH_QUOTE || c == CH_BSLASH || c == CH_LF || c == CH_CR || c == CH_TAB) begin
      n = 3'd2;
    end else if (c inside {[PRINT_LO:PRINT_HI]}) begin
      n = 3'd1;
    end else begin
      n = 3'd6;
    end
    return n;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) begin
      d = CH_ZERO + {4'd0, v};
    end else begin
      d = CH_LOW_A + {4'd0, v} - 8'd10;
    end
    return d;
  endfunction

  // Character number idx of the escape of byte c.
  function automatic logic [7:0] esc_char(input logic [7:0] c, input logic [2:0] idx);
    logic [7:0] ch;
    logic [2:0] n;
    n = esc_len(c);
    ch = CH_BSLASH;
    if (n == 3'd1) begin
      ch = c;
    end else if (n == 3'd2) begin
      if (idx != 3'd0) begin
        case (c)
          CH_LF:   ch = CH_N;
          CH_CR:   ch = CH_R;
          CH_TAB:  ch = CH_T;
          default: ch = c;
        endcase
      end
    end else begin
      case (idx)
        3'd0:    ch = CH_BSLASH;
        3'd1:    ch = CH_U;
        3'd2:    ch = CH_ZERO;
        3'd3:    ch = CH_ZERO;
        3'd4:    ch = hex_digit(c[7:4]);
        default: ch = hex_digit(c[3:0]);
      endcase
    end
    return ch;
  endfunction

endpackage

>>> rtl/core/brje_ram.sv
module brje_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/byte_ring_buffer_json_escaper.sv
// Byte ring buffer with JSON string escaping on read. Push stores in_byte and
// answers with one result transfer; when the buffer already holds DEPTH bytes
// the oldest byte is overwritten and dropped_oldest is set. Pop removes the
// oldest byte and streams its JSON escape one character per result transfer
// (one, two or six characters, last_of_run on the final one); a pop on an
// empty buffer answers with a single result with was_empty set. Clear empties
// the buffer; unused action codes answer with one result and change nothing.
// stored_count is the fill level after the item, truncated to 11 bits. The
// block takes one input transfer at a time. Push, clear and empty pop answer
// with a registered result. A pop with data issues a synchronous read of the
// byte store, captures the byte and its escape length, then sends the escape
// through the output register character by character, holding while the
// output is stalled. The store has no reset; only state, pointers, fill count
// and output valid are cleared, so no clearing pass is needed after reset.
module byte_ring_buffer_json_escaper #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  brje_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output brje_pkg::out_item_t out_data_o
);
  import brje_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  state_e state_q, state_d;

  logic [AW-1:0] rd_ptr_q, rd_ptr_d;   // oldest byte
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;   // next free slot, oldest + fill wrapped
  logic [CW-1:0] fill_q, fill_d;

  logic [7:0] byte_q, byte_d;
  logic [2:0] len_q, len_d;
  logic [2:0] idx_q, idx_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  logic       out_ready;
  logic       in_accept;
  logic       ram_we;
  logic       ram_re;
  logic [7:0] ram_rdata;
  logic       is_full;
  logic       is_empty;

  // Output register is free when empty or being drained this cycle.
  assign out_ready = !out_valid_q || !out_stall_i;
  // Take one item at a time, and only when its first result has a slot.
  assign in_stall_o = (state_q != ST_IDLE) || !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign is_full  = (fill_q == FULL_CNT);
  assign is_empty = (fill_q == '0);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_ADDR) ? '0 : p + 1'b1;
  endfunction

  // The store is written only on a push in IDLE and read only on a pop in IDLE,
  // so a read and a write never share a cycle; a pop after a push sees the
  // written byte since the write lands on an earlier edge than the read.
  assign ram_we = in_accept && (in_data_i.action == ACT_PUSH);
  assign ram_re = in_accept && (in_data_i.action == ACT_POP) && !is_empty;

  brje_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(is_full ? rd_ptr_q : wr_ptr_q),
    .wdata_i(in_data_i.in_byte),
    .re_i   (ram_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    fill_d      = fill_q;
    byte_d      = byte_q;
    len_d       = len_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          out_data_d.out_char       = '0;
          out_data_d.last_of_run    = 1'b1;
          out_data_d.was_empty      = 1'b0;
          out_data_d.dropped_oldest = 1'b0;
          out_data_d.stored_count   = COUNT_W'(fill_q);
          case (in_data_i.action)
            ACT_PUSH: begin
              // Full: overwrite the oldest slot and advance both pointers.
              out_valid_d = 1'b1;
              if (is_full) begin
                rd_ptr_d = ptr_inc(rd_ptr_q);
                wr_ptr_d = ptr_inc(wr_ptr_q);
                out_data_d.dropped_oldest = 1'b1;
              end else begin
                wr_ptr_d = ptr_inc(wr_ptr_q);
                fill_d   = fill_q + 1'b1;
                out_data_d.stored_count = COUNT_W'(fill_q + 1'b1);
              end
            end
            ACT_POP: begin
              if (is_empty) begin
                out_valid_d = 1'b1;
                out_data_d.was_empty = 1'b1;
              end else begin
                // Read issued this edge; data arrives next cycle.
                rd_ptr_d = ptr_inc(rd_ptr_q);
                fill_d   = fill_q - 1'b1;
                state_d  = ST_READ;
              end
            end
            ACT_CLEAR: begin
              out_valid_d = 1'b1;
              rd_ptr_d    = '0;
              wr_ptr_d    = '0;
              fill_d      = '0;
              out_data_d.stored_count = '0;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        // Capture the popped byte and its escape length.
        byte_d  = ram_rdata;
        len_d   = esc_len(ram_rdata);
        idx_d   = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          out_valid_d               = 1'b1;
          out_data_d.out_char       = esc_char(byte_q, idx_q);
          out_data_d.last_of_run    = (idx_q == len_q - 1'b1);
          out_data_d.was_empty      = 1'b0;
          out_data_d.dropped_oldest = 1'b0;
          out_data_d.stored_count   = COUNT_W'(fill_q);
          idx_d = idx_q + 1'b1;
          if (idx_q == len_q - 1'b1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    len_q      <= len_d;
    idx_q      <= idx_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Fill level never exceeds the capacity.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT)
    else $error("fill level above capacity");

  // Empty or full buffer has both pointers on the same slot.
  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0 || fill_q == FULL_CNT) |-> (wr_ptr_q == rd_ptr_q))
    else $error("pointers disagree with fill level");

  // Push into a full buffer keeps the level and reports the drop.
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.action == ACT_PUSH && is_full)
    |=> (out_valid_o && out_data_o.dropped_oldest && fill_q == FULL_CNT))
    else $error("push on full buffer misreported");

  // Pop on an empty buffer answers without a read, with was_empty set, and stays in IDLE.
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.action == ACT_POP && is_empty)
    |=> (out_valid_o && out_data_o.was_empty && out_data_o.last_of_run
         && state_q == ST_IDLE))
    else $error("empty pop misreported");

  // Clear resets pointers and level.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.action == ACT_CLEAR)
    |=> (fill_q == '0 && rd_ptr_q == '0 && wr_ptr_q == '0))
    else $error("clear left state behind");

endmodule

>>> tb/byte_ring_buffer_json_escaper_tb.sv
`timescale 1ns / 1ps

module byte_ring_buffer_json_escaper_tb;
  import brje_pkg::*;

  localparam int unsigned DEPTH          = 1024;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;   // no operation behind this code
  localparam int unsigned DIR_N          = 26;
  localparam int unsigned LONG_HOLD_AT   = 120;    // result count that starts the long hold
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 20;

  // One row of the directed sequence. Rows marked typed carry their single
  // result written out by hand; the rest take the predictor's results.
  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         in_byte;
    logic               typed;
    logic               was_empty;
    logic [COUNT_W-1:0] count;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  // Predictor state: own copy of the ring, its oldest slot and fill level.
  logic [7:0]  ring_mem [DEPTH];
  int unsigned ring_head = 0;
  int unsigned ring_fill = 0;

  out_item_t   pending_chars [$];   // expected result transfers, oldest first
  int unsigned err_cnt      = 0;
  int unsigned sent_cnt     = 0;
  int unsigned result_cnt   = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;
  bit          send_idle_en = 1'b1;
  bit          recv_idle_en = 1'b1;

  dir_row_t dir_tab [DIR_N];

  byte_ring_buffer_json_escaper #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    string digits;
    digits = "0123456789abcdef";
    return digits[v];
  endfunction

  // Queue one expected result; the count reflects the fill level after the item.
  function automatic void push_result(input logic [7:0] ch, input logic last,
                                      input logic empty, input logic dropped);
    out_item_t res;
    res.out_char       = ch;
    res.last_of_run    = last;
    res.was_empty      = empty;
    res.dropped_oldest = dropped;
    res.stored_count   = COUNT_W'(ring_fill);
    pending_chars.push_back(res);
  endfunction

  // Advance the predictor by one accepted input transfer and queue its results.
  task automatic apply_action(input in_item_t it);
    logic [7:0] seq [6];
    int         n;
    logic [7:0] c;
    logic       dropped;
    dropped = 1'b0;
    case (it.action)
      ACT_PUSH: begin
        if (ring_fill < DEPTH) begin
          ring_mem[(ring_head + ring_fill) % DEPTH] = it.in_byte;
          ring_fill++;
        end else begin
          // Full: overwrite the oldest byte and advance past it.
          ring_mem[ring_head] = it.in_byte;
          ring_head = (ring_head + 1) % DEPTH;
          dropped = 1'b1;
        end
        push_result(8'h00, 1'b1, 1'b0, dropped);
      end
      ACT_CLEAR: begin
        ring_head = 0;
        ring_fill = 0;
        push_result(8'h00, 1'b1, 1'b0, 1'b0);
      end
      ACT_POP: begin
        if (ring_fill == 0) begin
          push_result(8'h00, 1'b1, 1'b1, 1'b0);
        end else begin
          c = ring_mem[ring_head];
          ring_head = (ring_head + 1) % DEPTH;
          ring_fill--;
          seq[0] = CH_BSLASH;
          case (c)
            CH_QUOTE, CH_BSLASH: begin
              seq[1] = c;
              n = 2;
            end
            CH_LF: begin
              seq[1] = CH_N;
              n = 2;
            end
            CH_CR: begin
              seq[1] = CH_R;
              n = 2;
            end
            CH_TAB: begin
              seq[1] = CH_T;
              n = 2;
            end
            default: begin
              if (c >= PRINT_LO && c <= PRINT_HI) begin
                seq[0] = c;
                n = 1;
              end else begin
                // Control and non-ASCII bytes: \u00 and two lowercase hex digits.
                seq[1] = CH_U;
                seq[2] = CH_ZERO;
                seq[3] = CH_ZERO;
                seq[4] = hex_char(c[7:4]);
                seq[5] = hex_char(c[3:0]);
                n = 6;
              end
            end
          endcase
          for (int k = 0; k < n; k++) begin
            push_result(seq[k], k == n - 1, 1'b0, 1'b0);
          end
        end
      end
      default: begin
        push_result(8'h00, 1'b1, 1'b0, 1'b0);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_item(input logic [1:0] act, input logic [7:0] b);
    in_item_t it;
    it.action  = act;
    it.in_byte = b;
    return it;
  endfunction

  // Bias a quarter of the bytes toward the ones with special escapes or that
  // sit on the edge of the printable range.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(3, 0) == 0) begin
      case ($urandom_range(8, 0))
        0:       b = CH_QUOTE;
        1:       b = CH_BSLASH;
        2:       b = CH_LF;
        3:       b = CH_CR;
        4:       b = CH_TAB;
        5:       b = 8'h1F;
        6:       b = PRINT_LO;
        7:       b = PRINT_HI;
        default: b = 8'h7F;
      endcase
    end
    return b;
  endfunction

  // Offer one item after a random gap, hold it until the transfer, then
  // update the predictor. Valid stays high across back-to-back items.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = send_idle_en ? $urandom_range(3, 0) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    apply_action(it);
    sent_cnt++;
    // Switch sender idling on and off so some stretches run with no gaps.
    if (sent_cnt % 40 == 0) begin
      send_idle_en = 1'($urandom_range(1, 0));
    end
  endtask

  // Drop valid and wait until every expected result has been seen.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  // Random mix: pushes and pops in about equal share keep the ring shallow so
  // most pops find data; clears and unused codes are sprinkled in.
  task automatic run_mixed(input int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(99, 0);
      if (r < 46) begin
        send_item(make_item(ACT_PUSH, pick_byte()));
      end else if (r < 90) begin
        send_item(make_item(ACT_POP, 8'($urandom)));
      end else if (r < 95) begin
        send_item(make_item(ACT_CLEAR, 8'($urandom)));
      end else begin
        send_item(make_item(ACT_UNUSED, 8'($urandom)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each transfer, then draw the stall before the next one
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_chars.size() == 0) begin
          $error("result transfer with nothing expected: 0x%0h", out_data_o);
          err_cnt++;
        end else begin
          want = pending_chars.pop_front();
          check_field("out_char", 16'(want.out_char), 16'(out_data_o.out_char));
          check_field("last_of_run", 16'(want.last_of_run), 16'(out_data_o.last_of_run));
          check_field("was_empty", 16'(want.was_empty), 16'(out_data_o.was_empty));
          check_field("dropped_oldest", 16'(want.dropped_oldest),
                      16'(out_data_o.dropped_oldest));
          check_field("stored_count", 16'(want.stored_count), 16'(out_data_o.stored_count));
        end
        result_cnt++;
        // Once, hold off for a long stretch while the sender keeps offering,
        // so the block backs up and stalls its input.
        if (result_cnt == LONG_HOLD_AT) begin
          stall_left = LONG_HOLD;
        end else begin
          stall_left = recv_idle_en ? $urandom_range(3, 0) : 0;
        end
        if (result_cnt % 64 == 0) begin
          recv_idle_en = 1'($urandom_range(1, 0));
        end
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // End the run if neither channel moves a transfer for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("byte_ring_buffer_json_escaper test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    out_item_t typed_res;

    // Directed part: empty pop, unused codes, one push of each escape class
    // (hex escape at both ends of the byte range and around the printable
    // range), pops for all but one of them, then a clear with data left and an empty pop.
    dir_tab = '{
      {ACT_POP,    8'h00,     1'b1, 1'b1, 11'd0},
      {ACT_UNUSED, 8'hFF,     1'b1, 1'b0, 11'd0},
      {ACT_PUSH,   8'h00,     1'b1, 1'b0, 11'd1},
      {ACT_PUSH,   8'hFF,     1'b1, 1'b0, 11'd2},
      {ACT_PUSH,   CH_QUOTE,  1'b1, 1'b0, 11'd3},
      {ACT_PUSH,   CH_BSLASH, 1'b1, 1'b0, 11'd4},
      {ACT_PUSH,   CH_LF,     1'b1, 1'b0, 11'd5},
      {ACT_PUSH,   CH_CR,     1'b1, 1'b0, 11'd6},
      {ACT_PUSH,   CH_TAB,    1'b1, 1'b0, 11'd7},
      {ACT_PUSH,   PRINT_LO,  1'b1, 1'b0, 11'd8},
      {ACT_PUSH,   PRINT_HI,  1'b1, 1'b0, 11'd9},
      {ACT_PUSH,   8'h7F,     1'b1, 1'b0, 11'd10},
      {ACT_PUSH,   8'h1F,     1'b1, 1'b0, 11'd11},
      {ACT_UNUSED, 8'h00,     1'b1, 1'b0, 11'd11},
      {ACT_POP,    8'h00,     1'b0, 1'b0, 11'd0},
      {ACT_POP,    8'hFF,     1'b0, 1'b0, 11'd0},
      {ACT_POP,    8'h00,     1'b0, 1'b0, 11'd0},
      {ACT_POP,    8'h00,     1'b0, 1'b0, 11'd0},
      {ACT_POP,    8'h00,     1'b0, 1'b0, 11'd0},
      {ACT_POP,    8'h00,     1'b0, 1'b0, 11'd0},
      {ACT_POP,    8'h00,     1'b0, 1'b0, 11'd0},
      {ACT_POP,    8'h00,     1'b0, 1'b0, 11'd0},
      {ACT_POP,    8'h00,     1'b0, 1'b0, 11'd0},
      {ACT_POP,    8'h00,     1'b0, 1'b0, 11'd0},
      {ACT_CLEAR,  8'h5A,     1'b1, 1'b0, 11'd0},
      {ACT_POP,    8'h00,     1'b1, 1'b1, 11'd0}
    };

    // Hold reset, then release it on a rising edge.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_N; r++) begin
      send_item(make_item(dir_tab[r].action, dir_tab[r].in_byte));
      if (dir_tab[r].typed) begin
        // Replace the predicted single result with the hand-written one.
        typed_res.out_char       = 8'h00;
        typed_res.last_of_run    = 1'b1;
        typed_res.was_empty      = dir_tab[r].was_empty;
        typed_res.dropped_oldest = 1'b0;
        typed_res.stored_count   = dir_tab[r].count;
        void'(pending_chars.pop_back());
        pending_chars.push_back(typed_res);
      end
    end

    // Sender pauses until the block has answered everything.
    drain();

    // Random mix; the long receiver hold falls in here.
    run_mixed(200);
    drain();

    // Fill past capacity so pushes overwrite the oldest byte, then work the
    // full ring with pops and pushes before clearing it.
    repeat (DEPTH + 40) send_item(make_item(ACT_PUSH, pick_byte()));
    repeat (80) begin
      send_item(make_item($urandom_range(1, 0) ? ACT_PUSH : ACT_POP, pick_byte()));
    end
    send_item(make_item(ACT_CLEAR, 8'($urandom)));

    run_mixed(200);

    // Wait out the remaining results, then keep watching for strays.
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("byte_ring_buffer_json_escaper test passed");
    end else begin
      $display("byte_ring_buffer_json_escaper test failed");
    end
    $finish;
  end

endmodule
